// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: whenever ante holds, cons must hold.
`define SBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define SBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/sbs_pkg.sv =====
`timescale 1ns / 1ps
package sbs_pkg;

    localparam int CFG_W     = 11;  // frame length and shift amount
    localparam int IDX_W     = 10;  // bin index on the input channel
    localparam int WORD_W    = 32;  // magnitude and phase words on the channels
    localparam int CFG_IDX_W = 3;   // register index on the configuration channel

    localparam logic [CFG_W-1:0] FRAME_LENGTH_RESET = 11'd1024;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LENGTH  = 3'd0,
        CFG_SHIFT_AMOUNT  = 3'd1,
        CFG_SHIFT_UP      = 3'd2,
        CFG_TAIL_MODE     = 3'd3,
        CFG_TARGET_SELECT = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        TAIL_LEAVE = 2'd0,
        TAIL_CLEAR = 2'd1,
        TAIL_WRAP  = 2'd2
    } t_tail_mode;

    typedef enum logic [1:0] {
        TGT_MAG  = 2'd0,
        TGT_PH   = 2'd1,
        TGT_BOTH = 2'd2
    } t_target;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FETCH = 1'b1
    } t_state;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  bin_index;
        logic [WORD_W-1:0] magnitude_in;
        logic [WORD_W-1:0] phase_in;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_W-1:0] magnitude_out;
        logic [WORD_W-1:0] phase_out;
        logic              out_of_range;
    } t_out_beat;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     write_data;
    } t_cfg_beat;

    // Controller to datapath.
    typedef struct packed {
        logic wr_en;     // store the input beat
        logic rd_en;     // launch the remapped store read
        logic load_out;  // capture the read data into the output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic slot_free; // output register empty or being drained this cycle
    } t_dp_status;

endpackage

// ===== hw/rtl/sbs_chan_if.sv =====
`timescale 1ns / 1ps
interface sbs_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sbs_ram.sv =====
`timescale 1ns / 1ps
module sbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sbs_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbs_ctrl import sbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_req_read,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_read) begin
                        o_cmd.rd_en = 1'b1;
                        n_state     = ST_FETCH;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                // hold until the output register can take the result
                if (i_status.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
        endcase
    end

    `SBS_ASSERT_IMPL(a_fetch_blocks_input, i_clk, i_rst_n, r_state == ST_FETCH, !o_in_ready, "input accepted while a read is in flight")
    `SBS_ASSERT_NEXT(a_read_enters_fetch, i_clk, i_rst_n, o_cmd.rd_en, r_state == ST_FETCH, "read launched without entering fetch")

endmodule

// ===== hw/rtl/sbs_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbs_dp import sbs_pkg::*; #(
    parameter int MAX_BINS     = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_en,
    input  t_cfg_beat  i_cfg,
    input  t_in_beat   i_in,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out
);

    localparam int AW      = $clog2(MAX_BINS);
    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int NCAP    = (MAX_BINS > CFG_MAX) ? CFG_MAX : MAX_BINS;
    localparam logic [CFG_W-1:0] N_CAP = CFG_W'(NCAP);

    // configuration bank
    logic [CFG_W-1:0] r_frame_length;
    logic [CFG_W-1:0] r_shift_amount;
    logic             r_shift_up;
    logic [1:0]       r_tail_mode;
    logic [1:0]       r_target_select;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length  <= FRAME_LENGTH_RESET;
            r_shift_amount  <= '0;
            r_shift_up      <= 1'b1;
            r_tail_mode     <= TAIL_LEAVE;
            r_target_select <= TGT_BOTH;
        end else if (i_cfg_en) begin
            unique case (i_cfg.reg_index)
                CFG_FRAME_LENGTH:  r_frame_length  <= i_cfg.write_data;
                CFG_SHIFT_AMOUNT:  r_shift_amount  <= i_cfg.write_data;
                CFG_SHIFT_UP:      r_shift_up      <= i_cfg.write_data[0];
                CFG_TAIL_MODE:     r_tail_mode     <= i_cfg.write_data[1:0];
                CFG_TARGET_SELECT: r_target_select <= i_cfg.write_data[1:0];
                default: ;
            endcase
        end
    end

    // index remap
    logic [CFG_W-1:0] n_bins;
    logic [CFG_W-1:0] s_eff;
    logic [CFG_W-1:0] n_minus_s;
    logic [CFG_W-1:0] idx;
    logic [CFG_W-1:0] src;
    logic             src_ok;
    logic             in_main;
    logic             oor;
    logic             shift_mag;
    logic             shift_ph;
    logic             wr_ok;
    logic [AW-1:0]    mag_addr;
    logic [AW-1:0]    ph_addr;

    always_comb begin
        n_bins = r_frame_length;
        if (n_bins == '0) begin
            n_bins = CFG_W'(1);
        end else if (n_bins > N_CAP) begin
            n_bins = N_CAP;
        end
        s_eff     = (r_shift_amount > n_bins) ? n_bins : r_shift_amount;
        n_minus_s = n_bins - s_eff;
        idx       = CFG_W'(i_in.bin_index);
        oor       = (idx >= n_bins);
        in_main   = r_shift_up ? (idx >= s_eff) : (idx < n_minus_s);
        src       = idx;
        src_ok    = 1'b1;
        priority if (s_eff == '0) begin
            src = idx;
        end else if (in_main) begin
            src = r_shift_up ? (idx - s_eff) : (idx + s_eff);
        end else if (r_tail_mode == TAIL_CLEAR) begin
            src_ok = 1'b0;
        end else if (r_tail_mode == TAIL_WRAP) begin
            src = r_shift_up ? (n_minus_s + idx) : (idx - n_minus_s);
        end else begin
            src = idx;
        end
        shift_mag = (r_target_select == TGT_MAG) || (r_target_select == TGT_BOTH);
        shift_ph  = (r_target_select == TGT_PH) || (r_target_select == TGT_BOTH);
        mag_addr  = i_cmd.wr_en ? AW'(idx) : (shift_mag ? AW'(src) : AW'(idx));
        ph_addr   = i_cmd.wr_en ? AW'(idx) : (shift_ph ? AW'(src) : AW'(idx));
        wr_ok     = (int'(i_in.bin_index) < MAX_BINS);
    end

    // stores
    logic                    ram_en;
    logic [SAMPLE_WIDTH-1:0] mag_q;
    logic [SAMPLE_WIDTH-1:0] ph_q;

    assign ram_en = i_cmd.wr_en ? wr_ok : i_cmd.rd_en;

    sbs_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_BINS)) u_mag_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (i_cmd.wr_en),
        .i_addr  (mag_addr),
        .i_wdata (SAMPLE_WIDTH'(i_in.magnitude_in)),
        .o_rdata (mag_q)
    );

    sbs_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_BINS)) u_ph_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (i_cmd.wr_en),
        .i_addr  (ph_addr),
        .i_wdata (SAMPLE_WIDTH'(i_in.phase_in)),
        .o_rdata (ph_q)
    );

    // per-read flags, travel alongside the store read
    logic r_zero_mag;
    logic r_zero_ph;
    logic r_oor;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_zero_mag <= oor || (shift_mag && !src_ok);
            r_zero_ph  <= oor || (shift_ph && !src_ok);
            r_oor      <= oor;
        end
    end

    // output register
    logic      r_out_valid;
    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.magnitude_out <= r_zero_mag ? '0 : WORD_W'(mag_q);
            r_out.phase_out     <= r_zero_ph ? '0 : WORD_W'(ph_q);
            r_out.out_of_range  <= r_oor;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out              = r_out;
    assign o_status.slot_free = !r_out_valid || i_out_ready;

    `SBS_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, i_cmd.load_out, r_out_valid, "loaded result not presented")
    `SBS_ASSERT_IMPL(a_oor_zero_payload, i_clk, i_rst_n, r_out_valid && r_out.out_of_range, (r_out.magnitude_out == '0) && (r_out.phase_out == '0), "out-of-range result carries data")

endmodule

// ===== hw/rtl/spectrum_bin_shifter.sv =====
`timescale 1ns / 1ps
// Spectrum bin shifter: holds one frame of MAX_BINS bins (magnitude and phase words) in two
// single-port RAMs. A write beat (req_type 0) stores one bin and produces no result; a
// write to an index at or beyond MAX_BINS is dropped. A read beat (req_type 1) asks for
// output bin i of the frame shifted up or down by shift_amount (saturated at the frame
// length); the vacated tail keeps its stored bins, reads zero, or wraps around, per
// tail_mode, and target_select picks which channels are shifted. A read at or beyond
// frame_length returns zeros with out_of_range set. Reading a bin that was never written
// returns undefined data. A read sends the remapped address to the RAMs in the accept cycle;
// the fetch state then loads the registered RAM read into the output register once it is
// free, accepting no beat meanwhile, so writes go in every cycle only while idle. The output
// register lets the next beat be accepted while a result waits to be taken. Configuration
// is written through i_cfg (always ready); the user must write it only while the block is
// idle, which the block does not enforce. No clearing pass runs after reset.
module spectrum_bin_shifter import sbs_pkg::*; #(
    parameter int MAX_BINS     = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    sbs_chan_if.sink    i_in,
    sbs_chan_if.source  o_out,
    sbs_chan_if.sink    i_cfg
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;
    logic       req_read;

    // configuration registers take a beat every cycle
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign req_read    = (i_in.data.req_type == REQ_READ);

    // sequencer: idle takes beats, fetch waits for the output register to take the store read
    sbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_read (req_read),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: configuration bank, index remap, stores and output register
    sbs_dp #(
        .MAX_BINS     (MAX_BINS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_en    (i_cfg.valid),
        .i_cfg       (i_cfg.data),
        .i_in        (i_in.data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out       (o_out.data)
    );

endmodule
